>>> rtl/core/broi_pkg.sv
// Shared widths, register indexes and reset values for the box-to-image ROI projection.
// No dependencies; imported by broi_div and box_to_image_roi_projection.
package broi_pkg;

   localparam int FOCAL_BITS  = 24;
   localparam int CENTER_BITS = 16;
   localparam int FIELD_BITS  = 16;
   // focal (Q.8, 24 bit) times a 16 bit coordinate, kept signed
   localparam int PROD_BITS   = 40;
   // depth divisor: positive 16 bit value, sign bit dropped
   localparam int DEN_BITS    = 15;
   // |product| >> 4 is below 2^35
   localparam int QUO_BITS    = 35;
   // quotient plus principal point, signed Q.4
   localparam int U_BITS      = 37;
   localparam int LFT_BITS    = U_BITS - 4;
   localparam int DIFF_BITS   = U_BITS + 1;
   localparam int EXT_BITS    = DIFF_BITS - 4;
   localparam int SAT_BITS    = 40;

   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FOCAL_X  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FOCAL_Y  = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y = 8'd3;

   localparam logic [FOCAL_BITS-1:0]  FOCAL_X_RESET  = 24'd134400;
   localparam logic [FOCAL_BITS-1:0]  FOCAL_Y_RESET  = 24'd134400;
   localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = 16'd5112;
   localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = 16'd3832;

endpackage

>>> rtl/core/broi_div.sv
// Pipelined restoring divider, one quotient bit per stage, QUO_BITS stages.
// Depends on broi_pkg. Carries the sign of the dividend alongside the quotient.
module broi_div
   import broi_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [QUO_BITS-1:0] num_in,
   input  logic [DEN_BITS-1:0] den_in,
   input  logic                neg_in,
   output logic [QUO_BITS-1:0] quo_out,
   output logic                neg_out
);

   logic [DEN_BITS-1:0] rem_ff [QUO_BITS];
   logic [QUO_BITS-1:0] num_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];
   logic [DEN_BITS-1:0] den_ff [QUO_BITS];
   logic                neg_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [DEN_BITS-1:0] rem_src;
      logic [QUO_BITS-1:0] num_src;
      logic [QUO_BITS-1:0] quo_src;
      logic [DEN_BITS-1:0] den_src;
      logic                neg_src;
      logic [DEN_BITS:0]   part;
      logic [DEN_BITS+1:0] diff;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = num_in;
         assign quo_src = '0;
         assign den_src = den_in;
         assign neg_src = neg_in;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign num_src = num_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
         assign neg_src = neg_ff[k-1];
      end

      // bring down the next dividend bit, try the subtract
      assign part = {rem_src, num_src[QUO_BITS-1]};
      assign diff = {1'b0, part} - {2'b00, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            if (diff[DEN_BITS+1]) begin
               rem_ff[k] <= part[DEN_BITS-1:0];
            end else begin
               rem_ff[k] <= diff[DEN_BITS-1:0];
            end
            num_ff[k] <= {num_src[QUO_BITS-2:0], 1'b0};
            quo_ff[k] <= {quo_src[QUO_BITS-2:0], ~diff[DEN_BITS+1]};
            den_ff[k] <= den_src;
            neg_ff[k] <= neg_src;
         end
      end
   end

   assign quo_out = quo_ff[QUO_BITS-1];
   assign neg_out = neg_ff[QUO_BITS-1];

endmodule

>>> rtl/core/box_to_image_roi_projection.sv
// Box-to-image ROI projection top level: pinhole projection of a 3D box to a 2D region.
// Depends on broi_pkg and broi_div.
//
// Each word on req_ is an axis-aligned box (millimetres, camera frame). The block projects
// its eight corners with u = trunc(fx*x/z) + cx, v = trunc(fy*y/z) + cy in Q.4, takes min
// and max over the corners and returns offset and extent truncated to whole pixels,
// saturated to COORD_BITS. The pipeline takes one word every cycle; a word passes through
// stages P and A, the 35-stage divider (one quotient bit per stage) and stages C to G.
// Eight dividers run side by side, one per distinct x/z and y/z pair. A stall on rsp_
// holds the whole pipeline. A non-positive depth gives an all-zero result with roi_valid
// low. Write the csr_ registers only while the block is empty.
module box_to_image_roi_projection
   import broi_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // low_x, low_y, low_z, high_x, high_y, high_z (16 bits each, from bit 0 up)
   input  logic [95:0]              req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // roi_left, roi_top, roi_width, roi_height (16 bits each, from bit 0 up)
   output logic [63:0]              rsp_tdata,
   // roi_valid (bit 0), roi_clipped (bit 1)
   output logic [1:0]               rsp_tuser,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int NUM_STAGES = QUO_BITS + 7;
   localparam int LAST       = NUM_STAGES - 1;
   localparam logic signed [SAT_BITS-1:0] S_HI = (SAT_BITS'(1) <<< (COORD_BITS - 1)) - 1;
   localparam logic signed [SAT_BITS-1:0] S_LO = -(SAT_BITS'(1) <<< (COORD_BITS - 1));
   localparam logic [SAT_BITS-1:0]        U_HI = (SAT_BITS'(1) << COORD_BITS) - 1;

   // configuration registers
   logic [FOCAL_BITS-1:0]  focal_x_ff, focal_y_ff;
   logic [CENTER_BITS-1:0] center_x_ff, center_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FOCAL_X_RESET;
         focal_y_ff  <= FOCAL_Y_RESET;
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_X:  focal_x_ff  <= csr_data;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_data;
            CSR_CENTER_X: center_x_ff <= csr_data[CENTER_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_data[CENTER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the output register is free or being drained
   logic en;
   logic vld_ff [NUM_STAGES];
   logic ok_ff  [NUM_STAGES];

   assign en         = !vld_ff[LAST] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAST];

   // unpack the input word
   logic signed [FIELD_BITS-1:0] low_x, low_y, low_z, high_x, high_y, high_z;
   assign low_x  = req_tdata[15:0];
   assign low_y  = req_tdata[31:16];
   assign low_z  = req_tdata[47:32];
   assign high_x = req_tdata[63:48];
   assign high_y = req_tdata[79:64];
   assign high_z = req_tdata[95:80];

   logic z_ok;
   assign z_ok = !low_z[FIELD_BITS-1] && (low_z != '0) &&
                 !high_z[FIELD_BITS-1] && (high_z != '0);

   // valid and depth-ok flags travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff[0] <= z_ok;
         for (int i = 1; i < NUM_STAGES; i++) begin
            ok_ff[i] <= ok_ff[i-1];
         end
      end
   end

   // stage P: focal times coordinate (0: fx*low_x, 1: fx*high_x, 2: fy*low_y, 3: fy*high_y)
   logic signed [PROD_BITS:0]   mul_in [4];
   logic signed [PROD_BITS-1:0] prod_ff [4];
   logic [DEN_BITS-1:0]         zl_p_ff, zh_p_ff;

   always_comb begin
      mul_in[0] = $signed({1'b0, focal_x_ff}) * low_x;
      mul_in[1] = $signed({1'b0, focal_x_ff}) * high_x;
      mul_in[2] = $signed({1'b0, focal_y_ff}) * low_y;
      mul_in[3] = $signed({1'b0, focal_y_ff}) * high_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= mul_in[i][PROD_BITS-1:0];
         end
         zl_p_ff <= low_z[DEN_BITS-1:0];
         zh_p_ff <= high_z[DEN_BITS-1:0];
      end
   end

   // stage A: magnitude, drop the four fraction bits that the 16*z divisor removes
   logic [PROD_BITS-1:0] mag_in [4];
   logic [QUO_BITS-1:0]  num_ff [4];
   logic                 sgn_ff [4];
   logic [DEN_BITS-1:0]  zl_a_ff, zh_a_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag_in[i] = prod_ff[i][PROD_BITS-1] ? -prod_ff[i] : prod_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            num_ff[i] <= mag_in[i][QUO_BITS+3:4];
            sgn_ff[i] <= prod_ff[i][PROD_BITS-1];
         end
         zl_a_ff <= zl_p_ff;
         zh_a_ff <= zh_p_ff;
      end
   end

   // dividers: j[2:1] picks the product, j[0] picks low or high depth
   logic [QUO_BITS-1:0]      quo [8];
   logic                     qneg [8];
   logic signed [U_BITS-1:0] u_ff [8];

   for (genvar j = 0; j < 8; j++) begin : g_corner
      logic [CENTER_BITS-1:0] ctr;

      broi_div u_div (
         .clock   (clock),
         .en      (en),
         .num_in  (num_ff[j/2]),
         .den_in  ((j % 2 == 1) ? zh_a_ff : zl_a_ff),
         .neg_in  (sgn_ff[j/2]),
         .quo_out (quo[j]),
         .neg_out (qneg[j])
      );

      assign ctr = (j < 4) ? center_x_ff : center_y_ff;

      // stage C: apply sign and add the principal point in one add/subtract
      always_ff @(posedge clock) begin
         if (en) begin
            if (qneg[j]) begin
               u_ff[j] <= $signed(U_BITS'(ctr)) - $signed(U_BITS'(quo[j]));
            end else begin
               u_ff[j] <= $signed(U_BITS'(ctr)) + $signed(U_BITS'(quo[j]));
            end
         end
      end
   end

   // stage D: min/max over the two depths (0,1: u for low/high x; 2,3: v for low/high y)
   logic signed [U_BITS-1:0] pmin_ff [4];
   logic signed [U_BITS-1:0] pmax_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            if (u_ff[2*i] < u_ff[2*i+1]) begin
               pmin_ff[i] <= u_ff[2*i];
               pmax_ff[i] <= u_ff[2*i+1];
            end else begin
               pmin_ff[i] <= u_ff[2*i+1];
               pmax_ff[i] <= u_ff[2*i];
            end
         end
      end
   end

   // stage E: min/max over the two coordinates
   logic signed [U_BITS-1:0] umin_ff, umax_ff, vmin_ff, vmax_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         umin_ff <= (pmin_ff[0] < pmin_ff[1]) ? pmin_ff[0] : pmin_ff[1];
         umax_ff <= (pmax_ff[0] > pmax_ff[1]) ? pmax_ff[0] : pmax_ff[1];
         vmin_ff <= (pmin_ff[2] < pmin_ff[3]) ? pmin_ff[2] : pmin_ff[3];
         vmax_ff <= (pmax_ff[2] > pmax_ff[3]) ? pmax_ff[2] : pmax_ff[3];
      end
   end

   // stage F: offset cut toward zero, extent as difference
   logic signed [U_BITS-1:0]   ubias, vbias;
   logic [DIFF_BITS-1:0]       udiff, vdiff;
   logic signed [LFT_BITS-1:0] left_ff, top_ff;
   logic [EXT_BITS-1:0]        wid_ff, hgt_ff;

   always_comb begin
      ubias = umin_ff + (umin_ff[U_BITS-1] ? U_BITS'(15) : U_BITS'(0));
      vbias = vmin_ff + (vmin_ff[U_BITS-1] ? U_BITS'(15) : U_BITS'(0));
      udiff = DIFF_BITS'(umax_ff) - DIFF_BITS'(umin_ff);
      vdiff = DIFF_BITS'(vmax_ff) - DIFF_BITS'(vmin_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         left_ff <= ubias[U_BITS-1:4];
         top_ff  <= vbias[U_BITS-1:4];
         wid_ff  <= udiff[DIFF_BITS-1:4];
         hgt_ff  <= vdiff[DIFF_BITS-1:4];
      end
   end

   // stage G: saturate into the output register
   logic signed [SAT_BITS-1:0] left_x, top_x;
   logic [SAT_BITS-1:0]        wid_x, hgt_x;
   logic [SAT_BITS-1:0]        left_s, top_s, wid_s, hgt_s;
   logic                       clip;
   logic [63:0]                data_ff;
   logic [1:0]                 user_ff;

   always_comb begin
      left_x = {{(SAT_BITS-LFT_BITS){left_ff[LFT_BITS-1]}}, left_ff};
      top_x  = {{(SAT_BITS-LFT_BITS){top_ff[LFT_BITS-1]}}, top_ff};
      wid_x  = SAT_BITS'(wid_ff);
      hgt_x  = SAT_BITS'(hgt_ff);
      clip   = 1'b0;
      left_s = left_x;
      top_s  = top_x;
      wid_s  = wid_x;
      hgt_s  = hgt_x;
      if (left_x > S_HI) begin
         left_s = S_HI;
         clip   = 1'b1;
      end else if (left_x < S_LO) begin
         left_s = S_LO;
         clip   = 1'b1;
      end
      if (top_x > S_HI) begin
         top_s = S_HI;
         clip  = 1'b1;
      end else if (top_x < S_LO) begin
         top_s = S_LO;
         clip  = 1'b1;
      end
      if (wid_x > U_HI) begin
         wid_s = U_HI;
         clip  = 1'b1;
      end
      if (hgt_x > U_HI) begin
         hgt_s = U_HI;
         clip  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (ok_ff[LAST-1]) begin
            data_ff <= {hgt_s[15:0], wid_s[15:0], top_s[15:0], left_s[15:0]};
            user_ff <= {clip, 1'b1};
         end else begin
            data_ff <= '0;
            user_ff <= '0;
         end
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

endmodule
